### sv/assert_macros.svh
// Assertion helpers used by the top-level RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge while out of reset.
`define SITR_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition never holds while out of reset.
`define SITR_NEVER(name, clk, rstn, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define SITR_ASSERT(name, clk, rstn, prop, msg)
`define SITR_NEVER(name, clk, rstn, cond, msg)

`endif

`endif

### sv/sitr_pkg.sv
package sitr_pkg;

  // Number of symbol slots held in the configuration registers.
  localparam int unsigned NUM_SLOTS  = 16;
  localparam int unsigned SYM_BITS   = 8;
  localparam int unsigned STEP_BITS  = 8;   // quotient bits produced per cycle
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [1:0] REG_BASE_LEN     = 2'd0;
  localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

  // Character codes.
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // Configuration as seen by the rest of the block.
  typedef struct packed {
    logic [4:0]                       base_len;
    logic [NUM_SLOTS*SYM_BITS-1:0]    symbols;
    logic                             ok;
  } cfg_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_RD,
    ST_WR
  } back_state_e;

  // Symbol byte for one digit value.
  function automatic logic [7:0] sym_of(input logic [NUM_SLOTS*SYM_BITS-1:0] syms,
                                        input logic [3:0] d);
    return syms[{d, 3'b000} +: SYM_BITS];
  endfunction

  // Bytes that may not appear in an alphabet.
  function automatic logic forbidden(input logic [7:0] c);
    return (c == CHAR_MINUS) || (c == CHAR_PLUS) || (c == CHAR_LF) ||
           (c == CHAR_VT) || (c == CHAR_TAB) || (c == CHAR_FF) ||
           (c == CHAR_CR) || (c == CHAR_SPACE) || (c == CHAR_NUL);
  endfunction

endpackage

### sv/signed_int_to_radix_text.sv
// Signed integer to text in a configurable radix.
// Input stream (s_axis_*): one signed value per item in the low bits of tdata.
// Output stream (m_axis_*): one text byte per item, most significant digit
// first, preceded by a minus sign for negative values; tlast marks the final
// byte of each value. Configuration writes (cfg_*) set the radix and the
// alphabet and are always taken; write them only while the block is idle.
// An invalid alphabet makes the block take values and emit nothing.
// Flow: each value passes through the queue into the divider, which finds
// one digit per pass over the value, STEP_BITS quotient bits at a time, from
// the least significant digit up; each output byte then takes a digit-buffer
// read (ST_RD) and an output register load (ST_WR).
// The divider and digit buffer serve one value at a time; a two-entry queue
// lets further values be taken while one is converted.
// Reset clears the configuration to zero (an invalid alphabet), empties the
// queue and drops any conversion in progress.
// When the receiver stalls, the output byte is held and the converter waits;
// once the queue is full, s_axis_tready_o falls.
module signed_int_to_radix_text #(
  parameter int unsigned MAX_SYMBOLS = 16,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0]   s_axis_tdata_i,  // value
  output logic                                       m_axis_tvalid_o,
  input  logic                                       m_axis_tready_i,
  output logic [7:0]                                 m_axis_tdata_o,  // text_byte
  output logic                                       m_axis_tlast_o,
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [1:0]                                 cfg_index_i,
  input  logic [63:0]                                cfg_data_i
);
  import sitr_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;

  cfg_t                  cfg;
  logic                  pop_valid, pop_ready, pop_neg;
  logic [VALUE_BITS-1:0] pop_mag;

  sitr_cfg #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sitr_front #(.VALUE_BITS(VALUE_BITS), .DATA_BITS(DATA_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_data_i    (s_axis_tdata_i),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_neg_o   (pop_neg),
    .pop_mag_o   (pop_mag)
  );

  sitr_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_neg_i   (pop_neg),
    .pop_mag_i   (pop_mag),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

  // A full queue always has an item waiting for the converter.
  `SITR_ASSERT(a_full_has_pending, clk_i, rst_ni, !s_axis_tready_o |-> pop_valid, "queue full but empty")
  // The converter is busy in the cycle after it takes an item.
  `SITR_ASSERT(a_busy_after_pop, clk_i, rst_ni, pop_valid && pop_ready |=> !pop_ready, "converter took two items")
  // A final byte is never the sign.
  `SITR_NEVER(a_last_not_sign, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tlast_o && (m_axis_tdata_o == CHAR_MINUS), "sign marked last")

endmodule

### sv/sitr_cfg.sv
module sitr_cfg #(
  parameter int unsigned MAX_SYMBOLS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [63:0]      cfg_data_i,
  output sitr_pkg::cfg_t   cfg_o
);
  import sitr_pkg::*;

  logic [4:0]  base_q;
  logic [63:0] sym_lo_q, sym_hi_q;
  logic [NUM_SLOTS*SYM_BITS-1:0] syms;
  logic        ok;

  assign cfg_ready_o = 1'b1;
  assign syms = {sym_hi_q, sym_lo_q};

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      sym_lo_q <= '0;
      sym_hi_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BASE_LEN:     base_q   <= cfg_data_i[4:0];
        REG_SYMBOLS_LOW:  sym_lo_q <= cfg_data_i;
        REG_SYMBOLS_HIGH: sym_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Alphabet check: radix range, forbidden bytes, duplicate symbols.
  always_comb begin
    ok = (base_q >= 5'd2) && (base_q <= 5'(MAX_SYMBOLS));
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if ((5'(i) < base_q) && forbidden(sym_of(syms, 4'(i)))) ok = 1'b0;
      for (int j = i + 1; j < NUM_SLOTS; j++) begin
        if ((5'(j) < base_q) && (sym_of(syms, 4'(i)) == sym_of(syms, 4'(j)))) ok = 1'b0;
      end
    end
  end

  assign cfg_o = '{base_len: base_q, symbols: syms, ok: ok};

endmodule

### sv/sitr_front.sv
module sitr_front #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned DATA_BITS  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sitr_pkg::cfg_t        cfg_i,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  logic [DATA_BITS-1:0]  s_data_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output logic                  pop_neg_o,
  output logic [VALUE_BITS-1:0] pop_mag_o
);
  import sitr_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [VALUE_BITS:0]   ent_q [QUEUE_DEPTH];
  logic [PW-1:0]         wp_q, rp_q;
  logic [CW-1:0]         cnt_q;
  logic [VALUE_BITS-1:0] value, mag;
  logic                  neg, push, pop;

  // Classify the item: sign and unsigned magnitude.
  assign value = s_data_i[VALUE_BITS-1:0];
  assign neg   = value[VALUE_BITS-1];
  assign mag   = neg ? (~value + 1'b1) : value;

  assign s_ready_o   = (cnt_q != CW'(QUEUE_DEPTH));
  // Items that meet an invalid alphabet are taken and dropped.
  assign push        = s_valid_i && s_ready_o && cfg_i.ok;
  assign pop_valid_o = (cnt_q != '0);
  assign pop         = pop_valid_o && pop_ready_i;
  assign {pop_neg_o, pop_mag_o} = ent_q[rp_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) ent_q[wp_q] <= {neg, mag};
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= PW'(wp_q + 1'b1);
      if (pop)  rp_q <= PW'(rp_q + 1'b1);
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### sv/sitr_back.sv
module sitr_back #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sitr_pkg::cfg_t        cfg_i,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  logic                  pop_neg_i,
  input  logic [VALUE_BITS-1:0] pop_mag_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  out_last_o
);
  import sitr_pkg::*;

  localparam int unsigned PW     = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int unsigned NCHUNK = PW / STEP_BITS;
  localparam int unsigned KW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int unsigned AW     = $clog2(VALUE_BITS);
  localparam int unsigned NW     = $clog2(VALUE_BITS + 1);

  back_state_e       state_q, state_d;
  logic [PW-1:0]     sh_q, sh_d, sh_step;
  logic [3:0]        rem_q, rem_d;
  logic [KW-1:0]     chunk_q, chunk_d;
  logic [NW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic              neg_q, neg_d;
  logic              ov_q, ov_d, last_q, last_d;
  logic [7:0]        byte_q, byte_d;
  logic [4:0]        r5;
  logic [STEP_BITS-1:0] qbits;
  logic              mem_we, slot_free;
  logic [3:0]        mem_q [VALUE_BITS];
  logic [3:0]        rd_q;

  // Long division of the shift register by the radix, STEP_BITS bits a cycle.
  always_comb begin
    r5    = {1'b0, rem_q};
    qbits = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      r5 = {r5[3:0], sh_q[PW-1-i]};
      if (r5 >= cfg_i.base_len) begin
        r5 = r5 - cfg_i.base_len;
        qbits[STEP_BITS-1-i] = 1'b1;
      end
    end
    sh_step = (sh_q << STEP_BITS) | PW'(qbits);
  end

  assign slot_free = !ov_q || out_ready_i;

  // Sequencer: divide into digits, then emit the sign of a negative value and the digits.
  always_comb begin
    state_d     = state_q;
    sh_d        = sh_q;
    rem_d       = rem_q;
    chunk_d     = chunk_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    neg_d       = neg_q;
    ov_d        = ov_q && !out_ready_i;
    byte_d      = byte_q;
    last_d      = last_q;
    mem_we      = 1'b0;
    pop_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          sh_d    = PW'(pop_mag_i);
          neg_d   = pop_neg_i;
          rem_d   = '0;
          chunk_d = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        sh_d    = sh_step;
        rem_d   = r5[3:0];
        chunk_d = KW'(chunk_q + 1'b1);
        if (chunk_q == KW'(NCHUNK - 1)) begin
          mem_we  = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          rem_d   = '0;
          chunk_d = '0;
          if ((sh_step == '0) || (cnt_q == NW'(VALUE_BITS - 1))) begin
            idx_d   = cnt_q[AW-1:0];
            state_d = neg_q ? ST_SIGN : ST_RD;
          end
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          byte_d  = CHAR_MINUS;
          last_d  = 1'b0;
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_WR;
      end
      ST_WR: begin
        if (slot_free) begin
          ov_d   = 1'b1;
          byte_d = sym_of(cfg_i.symbols, rd_q);
          last_d = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = ST_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Digit buffer, least significant digit first, registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[cnt_q[AW-1:0]] <= r5[3:0];
    rd_q <= mem_q[idx_q];
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  // Control and working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sh_q    <= '0;
      rem_q   <= '0;
      chunk_q <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      neg_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      sh_q    <= sh_d;
      rem_q   <= rem_d;
      chunk_q <= chunk_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      neg_q   <= neg_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule
